[hdl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define B2R_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define B2R_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define B2R_ASSERT(lbl, clk, rstn, prop, msg)

`define B2R_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

[hdl/b2r_pkg.sv]
package b2r_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] AsciiI = 8'h49;
  localparam logic [7:0] AsciiV = 8'h56;
  localparam logic [7:0] AsciiX = 8'h58;
  localparam logic [7:0] AsciiL = 8'h4c;
  localparam logic [7:0] AsciiC = 8'h43;
  localparam logic [7:0] AsciiD = 8'h44;
  localparam logic [7:0] AsciiM = 8'h4d;

  // decimal digits of one value; thousands already cleared when it was four
  typedef struct packed {
    logic [1:0] th;
    logic [3:0] hun;
    logic [3:0] ten;
    logic [3:0] one;
  } digits_t;

  // which of a position's three symbols a step of a digit uses
  typedef enum logic [1:0] {
    SK_UNIT,
    SK_FIVE,
    SK_NEXT
  } sym_kind_e;

  // number of symbols a decimal digit expands to
  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] n;
    case (d) inside
      4'd1, 4'd5:             n = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
      4'd3, 4'd7:             n = 3'd3;
      4'd8:                   n = 3'd4;
      default:                n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic sym_kind_e digit_kind(input logic [3:0] d, input logic [1:0] idx);
    sym_kind_e k;
    case (d) inside
      4'd4:        k = (idx == 2'd1) ? SK_FIVE : SK_UNIT;
      [4'd5:4'd8]: k = (idx == 2'd0) ? SK_FIVE : SK_UNIT;
      4'd9:        k = (idx == 2'd1) ? SK_NEXT : SK_UNIT;
      default:     k = SK_UNIT;
    endcase
    return k;
  endfunction

  // pos 0 units, 1 tens, 2 hundreds, 3 thousands
  function automatic logic [7:0] roman_sym(input logic [1:0] pos, input sym_kind_e k);
    logic [7:0] s;
    case (pos)
      2'd0: s = (k == SK_UNIT) ? AsciiI : (k == SK_FIVE) ? AsciiV : AsciiX;
      2'd1: s = (k == SK_UNIT) ? AsciiX : (k == SK_FIVE) ? AsciiL : AsciiC;
      2'd2: s = (k == SK_UNIT) ? AsciiC : (k == SK_FIVE) ? AsciiD : AsciiM;
      default: s = AsciiM;
    endcase
    return s;
  endfunction

endpackage

[hdl/b2r_front.sv]
module b2r_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [11:0]       value_i,
  output logic              busy_o,
  output logic              push_o,
  output b2r_pkg::digits_t  push_data_o,
  input  logic              full_i
);

  logic       a_valid_q, a_valid_d;
  logic [1:0] a_th_q, a_th_d;
  logic [9:0] a_rem_q, a_rem_d;

  logic       b_valid_q, b_valid_d;
  logic [1:0] b_th_q;
  logic [3:0] b_hun_q;
  logic [6:0] b_rem_q;

  logic        b_adv;
  logic        accept;
  logic [11:0] sub;
  logic [15:0] hun_prod;
  logic [3:0]  hun;
  logic [9:0]  rem2_full;
  logic [13:0] ten_prod;
  logic [3:0]  ten;
  logic [6:0]  one_full;

  assign b_adv  = !b_valid_q || !full_i;
  assign busy_o = a_valid_q && !b_adv;
  assign accept = start_i && !busy_o;

  // thousands by compare, a thousands digit of four emits nothing
  always_comb begin
    if (value_i >= 12'd4000) begin
      a_th_d = 2'd0;
      sub    = 12'd4000;
    end else if (value_i >= 12'd3000) begin
      a_th_d = 2'd3;
      sub    = 12'd3000;
    end else if (value_i >= 12'd2000) begin
      a_th_d = 2'd2;
      sub    = 12'd2000;
    end else if (value_i >= 12'd1000) begin
      a_th_d = 2'd1;
      sub    = 12'd1000;
    end else begin
      a_th_d = 2'd0;
      sub    = 12'd0;
    end
    a_rem_d = 10'(value_i - sub);
  end

  // hundreds: r * 41 / 4096 is exact for r below 1000
  assign hun_prod  = {6'd0, a_rem_q} * 16'd41;
  assign hun       = hun_prod[15:12];
  assign rem2_full = a_rem_q - 10'(hun) * 10'd100;

  // tens: r * 103 / 1024 is exact for r below 100
  assign ten_prod = {7'd0, b_rem_q} * 14'd103;
  assign ten      = ten_prod[13:10];
  assign one_full = b_rem_q - 7'(ten) * 7'd10;

  assign push_o            = b_valid_q && !full_i;
  assign push_data_o.th    = b_th_q;
  assign push_data_o.hun   = b_hun_q;
  assign push_data_o.ten   = ten;
  assign push_data_o.one   = one_full[3:0];

  always_comb begin
    a_valid_d = a_valid_q;
    b_valid_d = b_valid_q;
    if (b_adv) begin
      b_valid_d = a_valid_q;
      a_valid_d = accept;
    end else if (!a_valid_q) begin
      a_valid_d = accept;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_th_q  <= a_th_d;
      a_rem_q <= a_rem_d;
    end
    if (b_adv && a_valid_q) begin
      b_th_q  <= a_th_q;
      b_hun_q <= hun;
      b_rem_q <= rem2_full[6:0];
    end
  end

endmodule

[hdl/b2r_queue.sv]
module b2r_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b2r_pkg::digits_t  data_i,
  output logic              full_o,
  input  logic              pop_i,
  output b2r_pkg::digits_t  data_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (b2r_pkg::QueueDepth > 1) ? $clog2(b2r_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(b2r_pkg::QueueDepth + 1);

  b2r_pkg::digits_t mem_q [b2r_pkg::QueueDepth];

  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(b2r_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(b2r_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(b2r_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[hdl/b2r_back.sv]
module b2r_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b2r_pkg::digits_t  rec_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              valid_o,
  output logic [7:0]        symbol_o,
  output logic              empty_res_o,
  output logic              last_o
);

  logic       act_q, act_d;
  logic       emp_q, emp_d;
  logic [3:0] dig_q [4];
  logic [3:0] dig_d [4];
  logic [1:0] pos_q, pos_d;
  logic [1:0] idx_q, idx_d;

  logic       valid_q;
  logic [7:0] symbol_q;
  logic       empty_res_q;
  logic       last_q;

  logic [3:0] cur;
  logic [2:0] cur_len;
  logic       end_digit;
  logic       below_nz;
  logic [1:0] next_pos;
  logic       item_last;
  logic       load_nz;
  logic [1:0] load_pos;
  logic [7:0] sym;

  assign cur       = dig_q[pos_q];
  assign cur_len   = b2r_pkg::digit_len(cur);
  assign end_digit = ({1'b0, idx_q} == (cur_len - 3'd1));

  // next lower position that still has symbols
  always_comb begin
    below_nz = 1'b0;
    next_pos = 2'd0;
    for (int p = 0; p < 4; p++) begin
      if (2'(p) < pos_q && dig_q[p] != 4'd0) begin
        below_nz = 1'b1;
        next_pos = 2'(p);
      end
    end
  end

  assign item_last = emp_q || (end_digit && !below_nz);
  assign pop_o     = (!act_q || item_last) && !empty_i;

  always_comb begin
    dig_d[3] = {2'b00, rec_i.th};
    dig_d[2] = rec_i.hun;
    dig_d[1] = rec_i.ten;
    dig_d[0] = rec_i.one;
    load_nz  = 1'b0;
    load_pos = 2'd0;
    for (int p = 0; p < 4; p++) begin
      if (dig_d[p] != 4'd0) begin
        load_nz  = 1'b1;
        load_pos = 2'(p);
      end
    end
  end

  always_comb begin
    act_d = act_q;
    emp_d = emp_q;
    pos_d = pos_q;
    idx_d = idx_q;
    if (pop_o) begin
      act_d = 1'b1;
      emp_d = !load_nz;
      pos_d = load_pos;
      idx_d = 2'd0;
    end else if (act_q && item_last) begin
      act_d = 1'b0;
    end else if (act_q && end_digit) begin
      pos_d = next_pos;
      idx_d = 2'd0;
    end else if (act_q) begin
      idx_d = idx_q + 2'd1;
    end
  end

  assign sym = emp_q ? 8'd0 : b2r_pkg::roman_sym(pos_q, b2r_pkg::digit_kind(cur, idx_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      act_q   <= act_d;
      valid_q <= act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    emp_q       <= emp_d;
    pos_q       <= pos_d;
    idx_q       <= idx_d;
    symbol_q    <= sym;
    empty_res_q <= emp_q;
    last_q      <= item_last;
    if (pop_o) begin
      for (int p = 0; p < 4; p++) begin
        dig_q[p] <= dig_d[p];
      end
    end
  end

  assign valid_o     = valid_q;
  assign symbol_o    = symbol_q;
  assign empty_res_o = empty_res_q;
  assign last_o      = last_q;

endmodule

[hdl/binary_to_roman_numeral.sv]
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+---------------------------------
// input     | value_i                                 | start_i high, busy_o low
// result    | symbol_o, empty_res_o, last_o           | valid_o high for one cycle
//
// a value runs through a two stage digit splitter into a two entry queue;
// the symbol sequencer then gives one symbol per cycle; a numeral has
// 1 to 15 symbols, and a value with no symbols gives a single empty item
// when free, first symbol runs through splitter, queue, sequencer and output register
// busy_o rises only while both splitter stages hold a value and the queue is full
// reset clears all valid flags and the queue pointers; the receiver never stalls

`include "assert_macros.svh"

module binary_to_roman_numeral (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [11:0] value_i,
  output logic        busy_o,
  output logic        valid_o,
  output logic [7:0]  symbol_o,
  output logic        empty_res_o,
  output logic        last_o
);

  // digits handed from the splitter to the queue
  b2r_pkg::digits_t push_data;
  b2r_pkg::digits_t pop_data;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;

  // empty item that is not alone or carries a symbol
  logic             bad_empty;

  // front: thousands by compare, hundreds and tens by reciprocal multiply
  b2r_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .value_i     (value_i),
    .busy_o      (busy_o),
    .push_o      (q_push),
    .push_data_o (push_data),
    .full_i      (q_full)
  );

  // decouples digit splitting from symbol emission
  b2r_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (pop_data),
    .empty_o (q_empty)
  );

  // back: walks digits most significant first, one symbol per cycle,
  // and pops the next entry in the same cycle as it forms the last symbol
  b2r_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (pop_data),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .valid_o     (valid_o),
    .symbol_o    (symbol_o),
    .empty_res_o (empty_res_o),
    .last_o      (last_o)
  );

  assign bad_empty = valid_o && empty_res_o && (!last_o || symbol_o != 8'd0);

  // symbols of one transaction leave as an unbroken run
  `B2R_ASSERT(a_run_contiguous, clk_i, rst_ni, valid_o && !last_o |=> valid_o, "symbol run broken")

  // an empty item stands alone and carries no symbol
  `B2R_ASSERT_NEVER(a_empty_alone, clk_i, rst_ni, bad_empty, "bad empty item")

  // every queue pop shows up at the result ports after the sequencer state and output register
  `B2R_ASSERT(a_pop_to_result, clk_i, rst_ni, q_pop |-> ##2 valid_o, "pop without result")

endmodule

[bench/binary_to_roman_numeral_tb.sv]
module binary_to_roman_numeral_tb;

  // run-length guard: about 350 values at up to 15 symbols plus a gap of up to
  // MaxGap each stay far below this limit, which leaves plenty of margin
  localparam int unsigned CycleLimit  = 200000;
  // quiet cycles after the last symbol, well past the first-symbol latency
  localparam int unsigned QuietCycles = 24;
  localparam int unsigned MaxGap      = 12;

  // one symbol transaction as it shows up on the result ports
  typedef struct packed {
    logic [7:0] symbol;
    logic       empty_res;
    logic       last;
  } roman_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic [11:0] value_i;
  logic        busy_o;
  logic        valid_o;
  logic [7:0]  symbol_o;
  logic        empty_res_o;
  logic        last_o;

  // symbols still owed by the block, oldest first
  roman_item_t pending_symbols[$];
  // scratch run of symbols for the value being predicted
  logic [7:0]  numeral_run[$];

  int unsigned mismatches     = 0;
  int unsigned values_sent    = 0;
  int unsigned symbols_seen   = 0;
  int unsigned empties_seen   = 0;
  int unsigned longest_run    = 0;
  int unsigned cycle_count    = 0;
  int unsigned run_len        = 0;

  binary_to_roman_numeral i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .value_i     (value_i),
    .busy_o      (busy_o),
    .valid_o     (valid_o),
    .symbol_o    (symbol_o),
    .empty_res_o (empty_res_o),
    .last_o      (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // hard stop in case the block hangs or drops symbols
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d symbols still owed", $time, cycle_count,
               pending_symbols.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // numeral predictor
  // ---------------------------------------------------------------------------

  // ascii code of the unit, five or next-unit symbol of a decimal place
  function automatic logic [7:0] place_symbol(input int unsigned place,
                                              input b2r_pkg::sym_kind_e role);
    logic [7:0] unit_sym;
    logic [7:0] five_sym;
    logic [7:0] next_sym;
    case (place)
      0: begin
        unit_sym = b2r_pkg::AsciiI; five_sym = b2r_pkg::AsciiV; next_sym = b2r_pkg::AsciiX;
      end
      1: begin
        unit_sym = b2r_pkg::AsciiX; five_sym = b2r_pkg::AsciiL; next_sym = b2r_pkg::AsciiC;
      end
      default: begin
        unit_sym = b2r_pkg::AsciiC; five_sym = b2r_pkg::AsciiD; next_sym = b2r_pkg::AsciiM;
      end
    endcase
    if (role == b2r_pkg::SK_FIVE) return five_sym;
    if (role == b2r_pkg::SK_NEXT) return next_sym;
    return unit_sym;
  endfunction

  // expand one decimal digit into its symbols, subtractive forms for 4 and 9
  function automatic void append_digit(input int unsigned digit, input int unsigned place);
    case (digit)
      1, 2, 3: begin
        repeat (digit) numeral_run.push_back(place_symbol(place, b2r_pkg::SK_UNIT));
      end
      4: begin
        numeral_run.push_back(place_symbol(place, b2r_pkg::SK_UNIT));
        numeral_run.push_back(place_symbol(place, b2r_pkg::SK_FIVE));
      end
      5, 6, 7, 8: begin
        numeral_run.push_back(place_symbol(place, b2r_pkg::SK_FIVE));
        repeat (digit - 5) numeral_run.push_back(place_symbol(place, b2r_pkg::SK_UNIT));
      end
      9: begin
        numeral_run.push_back(place_symbol(place, b2r_pkg::SK_UNIT));
        numeral_run.push_back(place_symbol(place, b2r_pkg::SK_NEXT));
      end
      default: ;
    endcase
  endfunction

  // queue up every symbol transaction that one accepted value must produce
  function automatic void predict_numeral(input logic [11:0] value);
    int unsigned   thousands;
    int unsigned   remainder;
    roman_item_t   item;
    thousands = value / 1000;
    remainder = value % 1000;
    numeral_run.delete();
    // a thousands digit of four contributes nothing at all
    if (thousands <= 3) begin
      repeat (thousands) numeral_run.push_back(b2r_pkg::AsciiM);
    end
    append_digit(remainder / 100, 2);
    append_digit((remainder / 10) % 10, 1);
    append_digit(remainder % 10, 0);
    if (numeral_run.size() == 0) begin
      // zero, or exactly 4000: a single flagged empty transaction
      item.symbol    = 8'h00;
      item.empty_res = 1'b1;
      item.last      = 1'b1;
      pending_symbols.push_back(item);
    end else begin
      foreach (numeral_run[k]) begin
        item.symbol    = numeral_run[k];
        item.empty_res = 1'b0;
        item.last      = (k == numeral_run.size() - 1);
        pending_symbols.push_back(item);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: the block cannot be stalled, so every strobe is a transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    roman_item_t want;
    if (rst_ni === 1'b1 && valid_o === 1'b1) begin
      symbols_seen <= symbols_seen + 1;
      if (empty_res_o === 1'b1) empties_seen <= empties_seen + 1;
      if (pending_symbols.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none, got symbol=%h empty=%b last=%b",
                 $time, symbol_o, empty_res_o, last_o);
      end else begin
        want = pending_symbols.pop_front();
        if (symbol_o !== want.symbol) begin
          mismatches++;
          $display("%0t: symbol mismatch, expected %h (%s), actual %h", $time, want.symbol,
                   want.symbol, symbol_o);
        end
        if (empty_res_o !== want.empty_res) begin
          mismatches++;
          $display("%0t: empty_res mismatch, expected %b, actual %b", $time, want.empty_res,
                   empty_res_o);
        end
        if (last_o !== want.last) begin
          mismatches++;
          $display("%0t: last mismatch, expected %b, actual %b", $time, want.last, last_o);
        end
      end
      // track the longest numeral seen for the summary
      if (last_o === 1'b1) begin
        if (run_len + 1 > longest_run) longest_run <= run_len + 1;
        run_len <= 0;
      end else begin
        run_len <= run_len + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // hold start until the block takes the value, then idle for gap cycles;
  // with a zero gap start simply stays high for the next transaction
  task automatic send_value(input logic [11:0] value, input int unsigned gap);
    start_i <= 1'b1;
    value_i <= value;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predict_numeral(value);
    values_sent++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk_i);
  endtask

  // mostly random gaps, with at least a quarter back-to-back
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MaxGap);
  endfunction

  // spread values over the shapes that matter: long numerals, the dead
  // thousands range, small numbers and fully random words
  function automatic logic [11:0] pick_value();
    int unsigned v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 4095);
      1: v = $urandom_range(0, 99);
      2: v = $urandom_range(3000, 3999);
      3: v = $urandom_range(4000, 4095);
      4: v = $urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100
             + $urandom_range(0, 9) * 10 + $urandom_range(0, 9);
      default: v = $urandom_range(0, 20);
    endcase
    return v[11:0];
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, every digit shape and the empty cases
  task automatic test_directed();
    logic [11:0] corners[$];
    corners = '{12'd0, 12'd1, 12'd3, 12'd4, 12'd5, 12'd8, 12'd9, 12'd40, 12'd49, 12'd90,
                12'd99, 12'd400, 12'd444, 12'd494, 12'd900, 12'd999, 12'd1000, 12'd1994,
                12'd3888, 12'd3999, 12'd4000, 12'd4001, 12'd4095, 12'd2730, 12'd1365};
    foreach (corners[k]) send_value(corners[k], $urandom_range(0, MaxGap));
  endtask

  task automatic test_random_values(input int unsigned count);
    repeat (count) send_value(pick_value(), pick_gap());
  endtask

  // start held high the whole time so the splitter queue fills and busy rises
  task automatic test_back_to_back(input int unsigned count);
    repeat (count) send_value(pick_value(), 0);
  endtask

  // short bursts, each followed by a full drain of the symbol stream
  task automatic test_drain_pause(input int unsigned rounds);
    repeat (rounds) begin
      repeat ($urandom_range(1, 8)) send_value(pick_value(), pick_gap());
      wait_drained();
    end
  endtask

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    value_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_values(150);
    test_back_to_back(60);
    test_drain_pause(4);
    test_random_values(90);

    wait_drained();
    repeat (QuietCycles) @(posedge clk_i);

    $display("%0d values converted, %0d symbols checked (%0d empty, longest numeral %0d)",
             values_sent, symbols_seen, empties_seen, longest_run);
    $display("random gaps of 0..%0d cycles, back-to-back bursts and full drains, %0d cycles",
             MaxGap, cycle_count);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[binary_to_roman_numeral.f]
+incdir+hdl
hdl/b2r_pkg.sv
hdl/b2r_front.sv
hdl/b2r_queue.sv
hdl/b2r_back.sv
hdl/binary_to_roman_numeral.sv
bench/binary_to_roman_numeral_tb.sv
